// ===== design/contact_phase_segmenter_assert.svh =====
// Assertion macros shared by the contact phase segmenter modules.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef CONTACT_PHASE_SEGMENTER_ASSERT_SVH
`define CONTACT_PHASE_SEGMENTER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked at every rising edge outside reset.
`define CPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen at a rising edge outside reset.
`define CPS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `CPS_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define CPS_ASSERT(label, clk, rst_n, prop, msg)
`define CPS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/cps_pkg.sv =====
// Package for the contact phase segmenter: payload types, segmenter state,
// queue sizing and the run-closing function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cps_pkg;

  localparam int TIME_BITS      = 32;
  localparam int MIN_SWING_BITS = 32;
  localparam int MAX_RESULTS    = 3;
  localparam int RES_CNT_W      = 2;
  // Queue depth must be a power of two so the pointers wrap on their own.
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [TIME_BITS-1:0]      tick_t;
  typedef logic [MIN_SWING_BITS-1:0] min_swing_t;
  typedef logic [RES_CNT_W-1:0]      res_cnt_t;

  typedef struct packed {
    logic  in_contact;
    tick_t boundary_time;
    logic  seq_last;
  } in_item_t;

  typedef struct packed {
    logic  phase_is_swing;
    tick_t phase_start;
    logic  start_open;
    tick_t phase_end;
    logic  end_open;
    logic  final_phase;
  } out_item_t;

  // All results caused by one input beat, in delivery order.
  typedef struct packed {
    res_cnt_t                      cnt;
    out_item_t [MAX_RESULTS-1:0]   item;
  } bundle_t;

  typedef struct packed {
    logic  in_seq;
    logic  run_swing;
    tick_t run_start;
    logic  run_first;
    logic  held_valid;
    tick_t held_start;
    logic  held_start_open;
    tick_t held_end;
    logic  merging;
  } seg_state_t;

  localparam seg_state_t SEG_STATE_RESET = '{
    in_seq:          1'b0,
    run_swing:       1'b0,
    run_start:       '0,
    run_first:       1'b1,
    held_valid:      1'b0,
    held_start:      '0,
    held_start_open: 1'b0,
    held_end:        '0,
    merging:         1'b0
  };

  // Outcome of closing one run: new state and up to two results,
  // slot 0 delivered before slot 1.
  typedef struct packed {
    seg_state_t      st;
    logic [1:0]      valid;
    out_item_t [1:0] res;
  } close_t;

  function automatic out_item_t make_result(logic sw, tick_t st, logic so,
                                            tick_t en, logic eo, logic fin);
    out_item_t r;
    r.phase_is_swing = sw;
    r.phase_start    = so ? '0 : st;
    r.start_open     = so;
    r.phase_end      = eo ? '0 : en;
    r.end_open       = eo;
    r.final_phase    = fin;
    return r;
  endfunction

  // A swing is short when it runs backwards or lasts under the minimum.
  function automatic logic is_short(tick_t st, tick_t en, min_swing_t min_swing);
    tick_t diff;
    diff = en - st;
    return (en < st) || (64'(diff) < 64'(min_swing));
  endfunction

  function automatic close_t close_run(seg_state_t s, tick_t en, logic last,
                                       min_swing_t min_swing);
    close_t c;
    logic   inter;
    c       = '0;
    c.st    = s;
    inter   = !s.run_first && !last;
    if (!s.run_swing) begin
      if (s.merging && s.held_valid) begin
        c.st.held_end = en;
      end else begin
        c.st.held_valid      = 1'b1;
        c.st.held_start      = s.run_start;
        c.st.held_start_open = s.run_first;
        c.st.held_end        = en;
      end
      c.st.merging = 1'b0;
      if (last) begin
        c.res[0]        = make_result(1'b0, c.st.held_start, c.st.held_start_open,
                                      '0, 1'b1, 1'b1);
        c.valid[0]      = 1'b1;
        c.st.held_valid = 1'b0;
      end
    end else begin
      if (inter && s.held_valid && is_short(s.run_start, en, min_swing)) begin
        c.st.merging = 1'b1;
      end else begin
        if (s.held_valid) begin
          c.res[0]   = make_result(1'b0, s.held_start, s.held_start_open,
                                   s.held_end, 1'b0, 1'b0);
          c.valid[0] = 1'b1;
        end
        c.st.held_valid = 1'b0;
        c.st.merging    = 1'b0;
        c.res[1]   = make_result(1'b1, s.run_start, s.run_first, en, last, last);
        c.valid[1] = 1'b1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/cps_front.sv =====
// Front end of the contact phase segmenter: run tracking, swing filter and
// result bundling. Depends on cps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "contact_phase_segmenter_assert.svh"

module cps_front
  import cps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  min_swing_t cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  logic       q_full,
  output logic       push,
  output bundle_t    push_data
);

  min_swing_t      min_swing_r;
  seg_state_t      state_r, state_nxt;
  seg_state_t      s_mid;
  close_t          cls_mid, cls_last;
  out_item_t [3:0] cand;
  logic [3:0]      cand_v;
  out_item_t [3:0] slots;
  res_cnt_t        cnt;
  logic            swing;
  logic            accept;

  assign swing    = !in_data.in_contact;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    s_mid   = state_r;
    cls_mid = '0;
    if (!state_r.in_seq) begin
      s_mid.in_seq     = 1'b1;
      s_mid.run_swing  = swing;
      s_mid.run_start  = '0;
      s_mid.run_first  = 1'b1;
      s_mid.held_valid = 1'b0;
      s_mid.merging    = 1'b0;
    end else if (swing != state_r.run_swing) begin
      cls_mid         = close_run(state_r, in_data.boundary_time, 1'b0, min_swing_r);
      s_mid           = cls_mid.st;
      s_mid.run_swing = swing;
      s_mid.run_start = in_data.boundary_time;
      s_mid.run_first = 1'b0;
    end

    cls_last    = close_run(s_mid, '0, 1'b1, min_swing_r);
    state_nxt   = s_mid;
    cand        = {cls_last.res[1], cls_last.res[0], cls_mid.res[1], cls_mid.res[0]};
    cand_v      = {2'b00, cls_mid.valid};
    if (in_data.seq_last) begin
      state_nxt   = SEG_STATE_RESET;
      cand_v[3:2] = cls_last.valid;
    end

    // Pack the valid results to the front of the bundle, in order.
    slots = '0;
    cnt   = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        slots[cnt] = cand[i];
        cnt        = cnt + res_cnt_t'(1);
      end
    end
    push_data.cnt  = cnt;
    push_data.item = slots[MAX_RESULTS-1:0];
  end

  assign push = accept && (cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEG_STATE_RESET;
      min_swing_r <= '0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        min_swing_r <= cfg_wdata;
      end
    end
  end

  `CPS_ASSERT(a_front_merge_held, clk, rst_n,
    state_r.merging |-> (state_r.held_valid && !state_r.run_swing && state_r.in_seq),
    "merge pending without a held stance run")
  `CPS_ASSERT(a_front_seq_end, clk, rst_n,
    (accept && in_data.seq_last) |=> (!state_r.in_seq && !state_r.held_valid),
    "sequence state not cleared after its final beat")
  `CPS_ASSERT_NEVER(a_front_push_full, clk, rst_n, push && q_full,
    "result bundle pushed into a full queue")

endmodule

`default_nettype wire

// ===== design/cps_queue.sv =====
// Short queue of result bundles between the front end and the output stage.
// Depends on cps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "contact_phase_segmenter_assert.svh"

module cps_queue
  import cps_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head_data
);

  bundle_t                entries_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QUEUE_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QUEUE_CNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  `CPS_ASSERT_NEVER(a_queue_overflow, clk, rst_n, push && full,
    "push into a full queue")
  `CPS_ASSERT_NEVER(a_queue_underflow, clk, rst_n, pop && !head_valid,
    "pop from an empty queue")
  `CPS_ASSERT(a_queue_count, clk, rst_n,
    (push && !pop) |=> (count_r == $past(count_r) + QUEUE_CNT_W'(1)),
    "queue count lost a push")

endmodule

`default_nettype wire

// ===== design/cps_back.sv =====
// Output stage of the contact phase segmenter: walks each queued bundle and
// presents one result per beat from a registered output. Depends on cps_pkg
// and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "contact_phase_segmenter_assert.svh"

module cps_back
  import cps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  bundle_t   head_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  res_cnt_t  idx_r, idx_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t pick;
  logic      load;
  logic      bundle_done;

  assign load        = head_valid && (!out_valid_r || out_ready);
  assign bundle_done = (idx_r == head_data.cnt - res_cnt_t'(1));
  assign pop         = load && bundle_done;

  always_comb begin
    unique case (idx_r)
      2'd0:    pick = head_data.item[0];
      2'd1:    pick = head_data.item[1];
      default: pick = head_data.item[2];
    endcase

    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = bundle_done ? '0 : idx_r + res_cnt_t'(1);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= pick;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CPS_ASSERT(a_back_idx_range, clk, rst_n,
    head_valid |-> (head_data.cnt != '0 && idx_r < head_data.cnt),
    "bundle index outside the queued bundle")
  `CPS_ASSERT(a_back_idx_hold, clk, rst_n,
    (out_valid_r && !out_ready) |=> (idx_r == $past(idx_r)),
    "bundle index moved during an output stall")
  `CPS_ASSERT_NEVER(a_back_pop_empty, clk, rst_n, pop && !head_valid,
    "bundle released while the queue is empty")

endmodule

`default_nettype wire

// ===== design/contact_phase_segmenter.sv =====
// Top level of the contact phase segmenter: front end, bundle queue and
// output stage. Depends on cps_pkg, cps_front, cps_queue and cps_back.
//
//   Channel   Ports                              Beat carries
//   -------   --------------------------------   ------------------------------
//   input     in_valid / in_ready / in_data      one phase (in_item_t)
//   result    out_valid / out_ready / out_data   one stance or swing run
//   config    cfg_we / cfg_wdata                 min_swing, no wait
//
// An input beat is taken every cycle while the four-entry bundle queue has room.
// Each beat yields zero to three results; the output register drains one per
// cycle while out_ready is high, so sustained input rate is one beat per cycle
// while beats average at most one result each. A beat's results pass the bundle
// queue, then the output register. Reset (rst_n low at a rising edge) clears
// the sequence state, the queue and the output valid, and sets min_swing to zero.
`timescale 1ns / 1ps
`default_nettype none

module contact_phase_segmenter
  import cps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  min_swing_t cfg_wdata
);

  // Front end to queue.
  logic    push;
  bundle_t push_data;
  logic    q_full;

  // Queue to output stage.
  logic    head_valid;
  bundle_t head_data;
  logic    pop;

  // The front end tracks the current run and the held stance run. When a
  // short intermediate swing closes, the held stance is kept open so the
  // following stance can be joined to it; all results of one beat are
  // packed into a single bundle.
  cps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // The queue lets the front end keep taking beats while the output side
  // is stalled or is still walking a bundle with several results.
  cps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // The output stage hands out the head bundle one result per beat and
  // releases the bundle as its last result is loaded.
  cps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/contact_phase_segmenter_test.sv =====
// Self-checking testbench for contact_phase_segmenter: directed and random phase
// sequences checked against an in-bench run predictor. Depends on cps_pkg and the
// RTL of the segmenter.
`timescale 1ns / 1ps

module contact_phase_segmenter_test;
  import cps_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The
  // longest quiet spell in a correct run is the forced receiver hold-off plus a
  // drain pause, well under this limit.
  localparam int HANG_LIMIT = 2000;
  // Pause after the last result before a register write or the end of the run.
  localparam int SETTLE_CYCLES = 16;
  // Length of the forced receiver hold-off in the backpressure test.
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int REPORT_LIMIT = 10;
  localparam tick_t TICK_MAX = '1;
  localparam min_swing_t SWING_MAX = '1;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  min_swing_t cfg_wdata;

  contact_phase_segmenter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Runs the segmenter is expected to emit, oldest first.
  out_item_t expected_runs[$];
  int        mismatches = 0;
  int        phases_sent = 0;
  int        idle_cycles = 0;
  // When set, neither side inserts random idle cycles.
  bit        calm = 1'b0;
  // Cycles left in a forced receiver hold-off.
  int        hold_left = 0;

  // Shadow copy of the min_swing register and of the segmenter state.
  min_swing_t min_swing_now = '0;
  bit         seq_open = 1'b0;
  bit         cur_swing = 1'b0;
  tick_t      cur_start = '0;
  bit         cur_first = 1'b1;
  bit         stance_held = 1'b0;
  tick_t      stance_start = '0;
  bit         stance_start_open = 1'b0;
  tick_t      stance_end = '0;
  bit         joining = 1'b0;

  // Queue one expected run. Open ends always read back as zero ticks.
  task automatic push_run(bit sw, tick_t st, bit so, tick_t en, bit eo, bit fin);
    out_item_t r;
    r.phase_is_swing = sw;
    r.phase_start    = so ? '0 : st;
    r.start_open     = so;
    r.phase_end      = eo ? '0 : en;
    r.end_open       = eo;
    r.final_phase    = fin;
    expected_runs = {expected_runs, r};
  endtask

  // Close the current run at tick en, or with an open end when last is set.
  // A stance run is only held here; it goes out once the next swing is kept or
  // the sequence ends. An inner swing that runs backwards or is shorter than
  // min_swing is swallowed, and the stance runs around it are joined.
  task automatic close_current_run(tick_t en, bit last);
    if (!cur_swing) begin
      if (!(joining && stance_held)) begin
        stance_held       = 1'b1;
        stance_start      = cur_start;
        stance_start_open = cur_first;
      end
      stance_end = en;
      joining    = 1'b0;
      if (last) begin
        push_run(1'b0, stance_start, stance_start_open, '0, 1'b1, 1'b1);
        stance_held = 1'b0;
      end
    end else if (!cur_first && !last && stance_held &&
                 (en < cur_start || (en - cur_start) < min_swing_now)) begin
      joining = 1'b1;
    end else begin
      if (stance_held) begin
        push_run(1'b0, stance_start, stance_start_open, stance_end, 1'b0, 1'b0);
      end
      stance_held = 1'b0;
      joining     = 1'b0;
      push_run(1'b1, cur_start, cur_first, en, last, last);
    end
  endtask

  // Advance the shadow state by one accepted phase beat.
  task automatic segment_phase(in_item_t ph);
    bit sw;
    sw = !ph.in_contact;
    if (!seq_open) begin
      // The first phase of a sequence opens a run; its boundary time is unused.
      seq_open    = 1'b1;
      cur_swing   = sw;
      cur_start   = '0;
      cur_first   = 1'b1;
      stance_held = 1'b0;
      joining     = 1'b0;
    end else if (sw != cur_swing) begin
      close_current_run(ph.boundary_time, 1'b0);
      cur_swing = sw;
      cur_start = ph.boundary_time;
      cur_first = 1'b0;
    end
    if (ph.seq_last) begin
      close_current_run('0, 1'b1);
      seq_open    = 1'b0;
      cur_swing   = 1'b0;
      cur_start   = '0;
      cur_first   = 1'b1;
      stance_held = 1'b0;
      joining     = 1'b0;
    end
  endtask

  // Every accepted input beat is predicted at the edge that takes it. Its
  // results pass the bundle queue and the output register before they come out,
  // so the expectation is always queued in time.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      segment_phase(in_data);
    end
  end

  // Result checker: each accepted beat is compared with the oldest expected run.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected run: swing=%0b start=%0h/%0b end=%0h/%0b final=%0b",
                   out_data.phase_is_swing, out_data.phase_start, out_data.start_open,
                   out_data.phase_end, out_data.end_open, out_data.final_phase);
        end
      end else begin
        want = expected_runs.pop_front();
        if (out_data.phase_is_swing !== want.phase_is_swing ||
            out_data.phase_start !== want.phase_start ||
            out_data.start_open !== want.start_open ||
            out_data.phase_end !== want.phase_end ||
            out_data.end_open !== want.end_open ||
            out_data.final_phase !== want.final_phase) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("run mismatch: expected swing=%0b start=%0h/%0b end=%0h/%0b final=%0b",
                     want.phase_is_swing, want.phase_start, want.start_open,
                     want.phase_end, want.end_open, want.final_phase);
            $display("              actual   swing=%0b start=%0h/%0b end=%0h/%0b final=%0b",
                     out_data.phase_is_swing, out_data.phase_start, out_data.start_open,
                     out_data.phase_end, out_data.end_open, out_data.final_phase);
          end
        end
      end
    end
  end

  // Receiver. A forced hold-off takes priority; otherwise ready drops at random with
  // a chance of nine in a hundred unless the bench is running calm.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  // Watchdog: a run in which no beat moves for too long has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("[contact_phase_segmenter] ERROR");
        $finish;
      end
    end
  end

  // Offer one phase beat and return at the edge that accepts it. Valid stays
  // high afterwards so back-to-back phases need no gap.
  task automatic offer_phase(bit contact, tick_t t, bit last);
    in_item_t ph;
    ph.in_contact    = contact;
    ph.boundary_time = t;
    ph.seq_last      = last;
    if (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ph;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    phases_sent++;
  endtask

  // Stop offering, wait for every expected run, then let the pipeline go quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The register is only written once the block is idle.
  task automatic set_min_swing(min_swing_t v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we        <= 1'b0;
    min_swing_now = v;
  endtask

  // One random sequence. Most phases alternate contact with boundary times that
  // advance by durations near min_swing, so swings are both kept and dropped;
  // some repeat a flag or jump to an arbitrary tick.
  task automatic play_sequence(int len, int unsigned span);
    bit    contact;
    tick_t t;
    contact = $urandom_range(1);
    t       = $urandom;
    offer_phase(contact, $urandom, len == 1);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(99) < 80) contact = !contact;
      if ($urandom_range(99) < 10) begin
        t = $urandom;
      end else begin
        t = t + $urandom_range(span, 0);
      end
      offer_phase(contact, t, i == len - 1);
    end
  endtask

  // Sequences of one phase: a lone stance and a lone swing, both ends open.
  // Then equal neighbours that merge before a final swing.
  task automatic test_single_runs();
    set_min_swing('0);
    offer_phase(1'b1, $urandom, 1'b1);
    offer_phase(1'b0, TICK_MAX, 1'b1);
    offer_phase(1'b1, '0, 1'b0);
    offer_phase(1'b1, 7, 1'b0);
    offer_phase(1'b0, 9, 1'b1);
  endtask

  // Short inner swings joining stance runs, including a join into the final
  // phase, a swing that runs backwards, a beat that yields three runs and a
  // short first swing that must be kept.
  task automatic test_stance_joining();
    set_min_swing(100);
    offer_phase(1'b1, $urandom, 1'b0);
    offer_phase(1'b0, 10, 1'b0);
    offer_phase(1'b1, 50, 1'b0);
    offer_phase(1'b0, 300, 1'b0);
    offer_phase(1'b1, 350, 1'b0);
    offer_phase(1'b1, 1000, 1'b1);
    offer_phase(1'b1, $urandom, 1'b0);
    offer_phase(1'b0, 500, 1'b0);
    offer_phase(1'b1, 400, 1'b0);
    offer_phase(1'b0, 600, 1'b1);
    offer_phase(1'b1, $urandom, 1'b0);
    offer_phase(1'b0, 10, 1'b0);
    offer_phase(1'b1, 1000, 1'b1);
    offer_phase(1'b0, $urandom, 1'b0);
    offer_phase(1'b1, 5, 1'b1);
  endtask

  // With min_swing at its largest, only a swing spanning the full tick range
  // survives in the middle of a sequence.
  task automatic test_extreme_min_swing();
    set_min_swing(SWING_MAX);
    offer_phase(1'b1, $urandom, 1'b0);
    offer_phase(1'b0, '0, 1'b0);
    offer_phase(1'b1, TICK_MAX, 1'b0);
    offer_phase(1'b0, TICK_MAX, 1'b1);
  endtask

  // The receiver holds off for a long stretch while phases keep coming, so the
  // bundle queue fills and in_ready has to drop.
  task automatic test_input_backpressure();
    set_min_swing(20);
    hold_left = HOLD_OFF_CYCLES;
    calm      = 1'b1;
    for (int i = 0; i < 30; i++) begin
      offer_phase(i[0], 32'(i * 30), i == 29 || i == 12);
    end
    calm = 1'b0;
  endtask

  task automatic test_random_sequences(min_swing_t ms, int beats, bit quiet);
    int          target;
    int unsigned span;
    set_min_swing(ms);
    calm   = quiet;
    target = phases_sent + beats;
    if (ms == 0) begin
      span = 64;
    end else if (ms <= 100000) begin
      span = 2 * ms;
    end else begin
      span = 32'hFFFF_FFFF;
    end
    while (phases_sent < target) begin
      play_sequence($urandom_range(1, 8), span);
    end
    calm = 1'b0;
  endtask

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_runs();
    test_stance_joining();
    test_extreme_min_swing();
    test_input_backpressure();
    test_random_sequences('0, 30, 1'b0);
    test_random_sequences(50, 30, 1'b1);
    test_random_sequences(min_swing_t'($urandom_range(5000, 1)), 30, 1'b0);
    test_random_sequences(SWING_MAX, 30, 1'b0);
    drain_results();

    if (mismatches == 0 && expected_runs.size() == 0) begin
      $display("[contact_phase_segmenter] OK");
    end else begin
      $display("[contact_phase_segmenter] ERROR");
    end
    $finish;
  end

endmodule
